// ----- hw/rtl/bls_pkg.sv -----
// Shared types, codes and constants for the bounded list search block.
package bls_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int VALUE_W   = 32;
	localparam int TYPE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 5;
	localparam int CNT_W     = 6;

	typedef enum logic [TYPE_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_SUM
	} fsm_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic               add_en;
		logic               rm_en;
		logic [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/bls_if.sv -----
// Request and response channel interfaces.
interface bls_req_if;
	logic                                valid;
	logic                                ready;
	logic [bls_pkg::TYPE_W-1:0]          req_type;
	logic signed [bls_pkg::VALUE_W-1:0]  value;

	modport source(output valid, req_type, value, input ready);
	modport sink(input valid, req_type, value, output ready);
endinterface

interface bls_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [bls_pkg::STATUS_W-1:0]        status;
	logic [bls_pkg::POS_W-1:0]           position;
	logic [bls_pkg::CNT_W-1:0]           entry_count;
	logic                                is_empty;
	logic                                is_full;
	logic signed [bls_pkg::VALUE_W-1:0]  min_value;
	logic signed [bls_pkg::VALUE_W-1:0]  max_value;

	modport source(output valid, status, position, entry_count, is_empty, is_full,
		min_value, max_value, input ready);
	modport sink(input valid, status, position, entry_count, is_empty, is_full,
		min_value, max_value, output ready);
endinterface

// ----- hw/rtl/bls_cell.sv -----
// One list slot: holds an entry, matches it and shifts it down on removal.
module bls_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  logic                            clk,
	input  bls_pkg::cell_ctl_t              ctl,
	input  logic [CW-1:0]                   count,
	input  logic                            hit_in,
	input  logic [bls_pkg::VALUE_W-1:0]     next_entry,
	output logic [bls_pkg::VALUE_W-1:0]     entry,
	output logic                            valid,
	output logic                            hit_out,
	output logic                            first
);

	logic [bls_pkg::VALUE_W-1:0] entry_q;
	logic                        match;

	assign valid   = CW'(IDX) < count;
	assign match   = valid && (entry_q == ctl.value);
	assign hit_out = hit_in | match;
	assign first   = match & ~hit_in;
	assign entry   = entry_q;

	// Append lands in the first free slot; removal pulls every slot at or
	// after the first hit from its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.add_en && (CW'(IDX) == count)) begin
			entry_q <= ctl.value;
		end else if (ctl.rm_en && hit_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ----- hw/rtl/bls_mmtree.sv -----
// Registered min/max tree over the cell entries, one register per level.
module bls_mmtree #(
	parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [bls_pkg::VALUE_W-1:0]  leaf_val [DEPTH],
	input  logic                                leaf_vld [DEPTH],
	output logic signed [bls_pkg::VALUE_W-1:0]  root_min,
	output logic signed [bls_pkg::VALUE_W-1:0]  root_max,
	output logic                                root_vld
);

	localparam int LVL = $clog2(DEPTH);
	localparam int NL  = 1 << LVL;
	localparam int NN  = 2 * NL - 1;

	logic signed [bls_pkg::VALUE_W-1:0] nmin [NN];
	logic signed [bls_pkg::VALUE_W-1:0] nmax [NN];
	logic                               nvld [NN];

	for (genvar j = 0; j < NL; j++) begin : g_leaf
		if (j < DEPTH) begin : g_real
			assign nmin[NL-1+j] = leaf_val[j];
			assign nmax[NL-1+j] = leaf_val[j];
			assign nvld[NL-1+j] = leaf_vld[j];
		end else begin : g_pad
			assign nmin[NL-1+j] = '0;
			assign nmax[NL-1+j] = '0;
			assign nvld[NL-1+j] = 1'b0;
		end
	end

	for (genvar k = 0; k < NL - 1; k++) begin : g_node
		logic signed [bls_pkg::VALUE_W-1:0] mn_q;
		logic signed [bls_pkg::VALUE_W-1:0] mx_q;
		logic                               vld_q;
		logic signed [bls_pkg::VALUE_W-1:0] a_mn, b_mn, a_mx, b_mx;
		logic                               a_v, b_v;

		assign a_mn = nmin[2*k+1];
		assign b_mn = nmin[2*k+2];
		assign a_mx = nmax[2*k+1];
		assign b_mx = nmax[2*k+2];
		assign a_v  = nvld[2*k+1];
		assign b_v  = nvld[2*k+2];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else begin
				vld_q <= a_v | b_v;
			end
		end

		// Take the valid side alone, or the better of two valid sides.
		always_ff @(posedge clk) begin
			if (a_v && (!b_v || a_mn <= b_mn)) begin
				mn_q <= a_mn;
			end else begin
				mn_q <= b_mn;
			end
			if (a_v && (!b_v || a_mx >= b_mx)) begin
				mx_q <= a_mx;
			end else begin
				mx_q <= b_mx;
			end
		end

		assign nmin[k] = mn_q;
		assign nmax[k] = mx_q;
		assign nvld[k] = vld_q;
	end

	assign root_min = nmin[0];
	assign root_max = nmax[0];
	assign root_vld = nvld[0];

endmodule

// ----- hw/rtl/bounded_list_search_minmax.sv -----
// Top level of the bounded list: chain of slot cells, min/max tree, control.
// Sequence: a beat taken in IDLE is matched and shifted in the cell chain in
// EXEC, waits in SUM while the result climbs the registered levels of the
// min/max tree, and is loaded into the output register once that is free.
// A new request is taken only after the previous result has been loaded,
// so the chain and the tree work on one request at a time.
// Reset: arst_n empties the list and drops any pending beat; no sweep needed.
module bounded_list_search_minmax #(
	parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bls_req_if.sink      req,
	bls_rsp_if.source    rsp
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL = $clog2(DEPTH);
	localparam int WW  = $clog2(LVL + 2);

	bls_pkg::fsm_t state_q, state_d;

	// Latched request.
	logic [bls_pkg::TYPE_W-1:0]  req_type_q;
	logic [bls_pkg::VALUE_W-1:0] value_q;

	// List bookkeeping and the request outcome.
	logic [CW-1:0]                  count_q;
	logic [bls_pkg::STATUS_W-1:0]   status_q;
	logic [PW-1:0]                  pos_q;
	logic [WW-1:0]                  wait_q;

	// Output register.
	logic                               out_valid_q;
	logic [bls_pkg::STATUS_W-1:0]       out_status_q;
	logic [bls_pkg::POS_W-1:0]          out_pos_q;
	logic [bls_pkg::CNT_W-1:0]          out_count_q;
	logic                               out_empty_q;
	logic                               out_full_q;
	logic signed [bls_pkg::VALUE_W-1:0] out_min_q;
	logic signed [bls_pkg::VALUE_W-1:0] out_max_q;

	// Chain wiring.
	bls_pkg::cell_ctl_t                 ctl;
	logic [bls_pkg::VALUE_W-1:0]        entry   [DEPTH];
	logic signed [bls_pkg::VALUE_W-1:0] entry_s [DEPTH];
	logic                               vld     [DEPTH];
	logic [DEPTH:0]                     hit;
	logic [DEPTH-1:0]                   first;
	logic [PW-1:0]                      hit_pos;

	logic signed [bls_pkg::VALUE_W-1:0] root_min, root_max;
	logic                               root_vld;

	// Control from the FSM.
	logic in_take, exec, load_out, out_free, full, any_hit;
	logic [31:0] cnt_ext, pos_ext;

	assign in_take  = req.valid && req.ready;
	assign exec     = (state_q == bls_pkg::FSM_EXEC);
	assign full     = (count_q == CW'(DEPTH));
	assign any_hit  = hit[DEPTH];
	assign out_free = !out_valid_q || rsp.ready;

	assign ctl.add_en = exec && (req_type_q == bls_pkg::REQ_ADD) && !full;
	assign ctl.rm_en  = exec && (req_type_q == bls_pkg::REQ_REMOVE);
	assign ctl.value  = value_q;

	// The first-hit token ripples from slot 0 toward the tail.
	assign hit[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [bls_pkg::VALUE_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt = entry[i];
		end else begin : g_mid
			assign nxt = entry[i+1];
		end

		bls_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.hit_in     (hit[i]),
			.next_entry (nxt),
			.entry      (entry[i]),
			.valid      (vld[i]),
			.hit_out    (hit[i+1]),
			.first      (first[i])
		);

		assign entry_s[i] = entry[i];
	end

	// Encode the one-hot first match into an index.
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				hit_pos = hit_pos | PW'(i);
			end
		end
	end

	bls_mmtree #(
		.DEPTH (DEPTH)
	) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.leaf_val (entry_s),
		.leaf_vld (vld),
		.root_min (root_min),
		.root_max (root_max),
		.root_vld (root_vld)
	);

	// Sequencer: take a beat, update the chain, wait out the tree, publish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bls_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			bls_pkg::FSM_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = bls_pkg::FSM_EXEC;
				end
			end
			bls_pkg::FSM_EXEC: begin
				state_d = bls_pkg::FSM_SUM;
			end
			bls_pkg::FSM_SUM: begin
				// Hold until the root has settled and the output slot is free.
				if ((wait_q == WW'(LVL)) && out_free) begin
					load_out = 1'b1;
					state_d  = bls_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = bls_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_type_q <= req.req_type;
			value_q    <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wait_q  <= '0;
		end else begin
			if (exec) begin
				wait_q <= '0;
				if (ctl.add_en) begin
					count_q <= count_q + CW'(1);
				end else if (ctl.rm_en && any_hit) begin
					count_q <= count_q - CW'(1);
				end
			end else if ((state_q == bls_pkg::FSM_SUM) && (wait_q != WW'(LVL))) begin
				wait_q <= wait_q + WW'(1);
			end
		end
	end

	// Outcome of the request, taken from the chain before it shifts.
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= bls_pkg::ST_NOT_FOUND;
			pos_q    <= '0;
			unique case (req_type_q)
				bls_pkg::REQ_ADD: begin
					if (full) begin
						status_q <= bls_pkg::ST_FULL;
					end else begin
						status_q <= bls_pkg::ST_DONE;
						pos_q    <= PW'(count_q);
					end
				end
				bls_pkg::REQ_REMOVE, bls_pkg::REQ_SEARCH: begin
					if (any_hit) begin
						status_q <= bls_pkg::ST_DONE;
						pos_q    <= hit_pos;
					end
				end
				default: begin
					status_q <= bls_pkg::ST_NOT_FOUND;
				end
			endcase
		end
	end

	assign cnt_ext = 32'(count_q);
	assign pos_ext = 32'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_pos_q    <= pos_ext[bls_pkg::POS_W-1:0];
			out_count_q  <= cnt_ext[bls_pkg::CNT_W-1:0];
			out_empty_q  <= (count_q == '0);
			out_full_q   <= full;
			// An empty list reports -1 for both extremes.
			out_min_q    <= root_vld ? root_min : '1;
			out_max_q    <= root_vld ? root_max : '1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.position    = out_pos_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.is_empty    = out_empty_q;
	assign rsp.is_full     = out_full_q;
	assign rsp.min_value   = out_min_q;
	assign rsp.max_value   = out_max_q;

endmodule

// ----- hw/rtl/bls_checker.sv -----
// Port-level checks on the response channel of the bounded list.
module bls_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rsp_valid,
	input  logic                                rsp_ready,
	input  logic [bls_pkg::STATUS_W-1:0]        status,
	input  logic [bls_pkg::POS_W-1:0]           position,
	input  logic [bls_pkg::CNT_W-1:0]           entry_count,
	input  logic                                is_empty,
	input  logic signed [bls_pkg::VALUE_W-1:0]  min_value,
	input  logic signed [bls_pkg::VALUE_W-1:0]  max_value
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(min_value) && $stable(status))
		else $error("response beat dropped or changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_ext: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> (min_value == -1) && (max_value == -1))
		else $error("empty list must report -1 extremes");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != bls_pkg::ST_DONE) |-> (position == '0))
		else $error("position nonzero on failed request");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !is_empty |-> (min_value <= max_value))
		else $error("min above max");

endmodule

bind bounded_list_search_minmax bls_checker u_bls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.position    (rsp.position),
	.entry_count (rsp.entry_count),
	.is_empty    (rsp.is_empty),
	.min_value   (rsp.min_value),
	.max_value   (rsp.max_value)
);

// ----- tb/bounded_list_search_minmax_tb.sv -----
// Self-checking testbench for the bounded list with search, removal and min/max report.
module bounded_list_search_minmax_tb;

	localparam int LIST_DEPTH = bls_pkg::DEPTH_DEF;
	localparam int POS_W = bls_pkg::POS_W;
	localparam int CNT_W = bls_pkg::CNT_W;
	// Random requests after the directed ones.
	localparam int RANDOM_REQS = 1780;
	// Response count window in which neither side idles.
	localparam int QUIET_FROM = 400;
	localparam int QUIET_TO = 700;
	// Response count at which the receiver starts its long hold-off, and its length.
	localparam int HOLD_AT = 1200;
	localparam int HOLD_CYCLES = 300;
	// Cycles to let pass after the last response: block latency plus margin.
	localparam int DRAIN_CYCLES = 20;
	localparam int TIMEOUT_UNITS = 400000;

	typedef bls_pkg::req_t    req_t;
	typedef bls_pkg::status_t status_t;

	typedef struct {
		req_t               kind;
		logic signed [31:0] value;
	} list_req_t;

	typedef struct {
		status_t               status;
		logic [POS_W-1:0]      position;
		logic [CNT_W-1:0]      entry_count;
		logic                  is_empty;
		logic                  is_full;
		logic signed [31:0]    min_value;
		logic signed [31:0]    max_value;
	} list_result_t;

	logic clk;
	logic arst_n;

	bls_req_if req_ch();
	bls_rsp_if rsp_ch();

	bounded_list_search_minmax #(.DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Requests waiting to be offered, and results owed by the block, oldest first.
	list_req_t    pending_reqs[$];
	list_result_t owed_results[$];

	// Shadow of the list contents, kept in insertion order.
	logic signed [31:0] shadow_list[LIST_DEPTH];
	int unsigned        shadow_cnt;

	// Multiset of values the stimulus believes are stored; steers removes and
	// searches toward values that will actually hit.
	logic signed [31:0] held_values[$];

	int unsigned sent_cnt;
	int unsigned rcv_cnt;
	int unsigned fail_cnt;
	int unsigned n_rejected;
	int unsigned n_missed;
	int unsigned n_full_seen;
	int unsigned n_empty_seen;

	// Long receiver hold-off, counted in the stall process.
	int unsigned hold_left;
	bit          hold_done;
	logic        hold_q;

	always #1 clk = ~clk;

	// Apply one request to the shadow list and work out the response it must produce.
	function automatic list_result_t apply_request(req_t kind, logic signed [31:0] v);
		list_result_t r;
		int           hit;
		r.status   = bls_pkg::ST_NOT_FOUND;
		r.position = '0;
		case (kind)
		bls_pkg::REQ_ADD: begin
			if (shadow_cnt < LIST_DEPTH) begin
				shadow_list[shadow_cnt] = v;
				r.position = POS_W'(shadow_cnt);
				shadow_cnt++;
				r.status = bls_pkg::ST_DONE;
			end else begin
				r.status = bls_pkg::ST_FULL;
			end
		end
		bls_pkg::REQ_REMOVE, bls_pkg::REQ_SEARCH: begin
			hit = -1;
			// Equality over all 32 bits; the first match wins.
			for (int i = 0; i < shadow_cnt; i++) begin
				if (hit < 0 && shadow_list[i] === v)
					hit = i;
			end
			if (hit >= 0) begin
				r.status = bls_pkg::ST_DONE;
				r.position = POS_W'(hit);
				if (kind == bls_pkg::REQ_REMOVE) begin
					// Close the gap: shift every later entry down one slot.
					for (int i = hit; i + 1 < shadow_cnt; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_cnt--;
				end
			end
		end
		default: ;  // the spare request code leaves the list alone and reports not found
		endcase
		r.entry_count = CNT_W'(shadow_cnt);
		r.is_empty = (shadow_cnt == 0);
		r.is_full = (shadow_cnt == LIST_DEPTH);
		r.min_value = -32'sd1;
		r.max_value = -32'sd1;
		if (shadow_cnt > 0) begin
			// Signed ordering for the extremes.
			r.min_value = shadow_list[0];
			r.max_value = shadow_list[0];
			for (int i = 1; i < shadow_cnt; i++) begin
				if (shadow_list[i] < r.min_value)
					r.min_value = shadow_list[i];
				if (shadow_list[i] > r.max_value)
					r.max_value = shadow_list[i];
			end
		end
		return r;
	endfunction

	// Random back-pressure on either side: a skip about 27 percent of the time, none in the quiet window.
	function automatic bit skip_this_cycle(int unsigned beats);
		if (beats >= QUIET_FROM && beats < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < 27;
	endfunction

	task automatic queue_req(req_t kind, logic signed [31:0] v);
		list_req_t item;
		item.kind = kind;
		item.value = v;
		pending_reqs.push_back(item);
	endtask

	task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, exp_val, act_val);
			fail_cnt++;
		end
	endtask

	// Value for an add: corners, small numbers, repeats of stored values, or anything.
	function automatic logic signed [31:0] pick_add_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			case ($urandom_range(4))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return 32'sd1;
			endcase
		end
		if (roll < 30)
			return $signed(32'($urandom_range(15))) - 32'sd8;
		if (roll < 65 && held_values.size() != 0)
			return held_values[$urandom_range(held_values.size() - 1)];
		return $signed($urandom);
	endfunction

	// Driver: offer the head of the pending queue; hold it until the block takes it.
	always @(posedge clk) begin : driver
		bit busy;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			busy = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				// Predict first, then drop from pending, so the end check never sees a gap.
				owed_results.push_back(apply_request(pending_reqs[0].kind,
					pending_reqs[0].value));
				pending_reqs.pop_front();
				sent_cnt++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_reqs.size() != 0 && !skip_this_cycle(rcv_cnt)) begin
					req_ch.valid <= 1'b1;
					req_ch.req_type <= pending_reqs[0].kind;
					req_ch.value <= pending_reqs[0].value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Once in the run, hold the receiver off long enough for the block to back up
	// and stall its input while the driver keeps offering.
	always @(posedge clk) begin : stall
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			hold_q <= (hold_left != 0);
		end else if (!hold_done && rcv_cnt >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			hold_q <= 1'b1;
		end else begin
			hold_q <= 1'b0;
		end
	end

	// Monitor: check each response beat against the oldest prediction and drive ready.
	always @(posedge clk) begin : monitor
		list_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rcv_cnt++;
				if (owed_results.size() == 0) begin
					$error("response beat with no request outstanding");
					fail_cnt++;
				end else begin
					want = owed_results.pop_front();
					compare_field("status", 32'(want.status), 32'(rsp_ch.status));
					compare_field("position", 32'(want.position), 32'(rsp_ch.position));
					compare_field("entry_count", 32'(want.entry_count),
						32'(rsp_ch.entry_count));
					compare_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
					compare_field("is_full", 32'(want.is_full), 32'(rsp_ch.is_full));
					compare_field("min_value", want.min_value, rsp_ch.min_value);
					compare_field("max_value", want.max_value, rsp_ch.max_value);
					if (want.status == bls_pkg::ST_FULL)
						n_rejected++;
					if (want.status == bls_pkg::ST_NOT_FOUND)
						n_missed++;
					if (want.is_full)
						n_full_seen++;
					if (want.is_empty)
						n_empty_seen++;
				end
			end
			if (hold_q)
				rsp_ch.ready <= 1'b0;
			else
				rsp_ch.ready <= !skip_this_cycle(rcv_cnt);
		end
	end

	// Watchdog.
	initial begin
		#(TIMEOUT_UNITS);
		$display("FAIL bounded_list_search_minmax");
		$finish;
	end

	initial begin : stimulus
		int unsigned        made;
		int unsigned        mode;
		int unsigned        span;
		int unsigned        roll;
		int unsigned        idx;
		req_t               kind;
		logic signed [31:0] v;

		// Known values on every input from time zero; hold reset.
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = bls_pkg::REQ_NOP;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		shadow_cnt = 0;
		sent_cnt = 0;
		rcv_cnt = 0;
		fail_cnt = 0;
		n_rejected = 0;
		n_missed = 0;
		n_full_seen = 0;
		n_empty_seen = 0;

		// Directed: requests on an empty list, the spare code, signed corners,
		// duplicates (first match wins), removal with shift, drain back to empty.
		queue_req(bls_pkg::REQ_SEARCH, 32'sd0);
		queue_req(bls_pkg::REQ_REMOVE, -32'sd1);
		queue_req(bls_pkg::REQ_NOP, 32'sd0);
		queue_req(bls_pkg::REQ_ADD, 32'sh8000_0000);
		queue_req(bls_pkg::REQ_ADD, 32'sh7FFF_FFFF);
		queue_req(bls_pkg::REQ_ADD, -32'sd1);
		queue_req(bls_pkg::REQ_ADD, 32'sd0);
		queue_req(bls_pkg::REQ_ADD, 32'sh8000_0000);
		queue_req(bls_pkg::REQ_ADD, 32'sd1);
		queue_req(bls_pkg::REQ_SEARCH, 32'sh8000_0000);
		queue_req(bls_pkg::REQ_SEARCH, 32'sd1);
		queue_req(bls_pkg::REQ_SEARCH, 32'sd2);
		queue_req(bls_pkg::REQ_SEARCH, 32'sh7FFF_FFFE);
		queue_req(bls_pkg::REQ_REMOVE, 32'sh8000_0000);
		queue_req(bls_pkg::REQ_SEARCH, 32'sh8000_0000);
		queue_req(bls_pkg::REQ_REMOVE, 32'sd1);
		queue_req(bls_pkg::REQ_REMOVE, 32'sh7FFF_FFFF);
		queue_req(bls_pkg::REQ_NOP, 32'sh5555_5555);
		queue_req(bls_pkg::REQ_REMOVE, -32'sd1);
		queue_req(bls_pkg::REQ_REMOVE, 32'sd0);
		queue_req(bls_pkg::REQ_REMOVE, 32'sh8000_0000);
		queue_req(bls_pkg::REQ_REMOVE, 32'sh8000_0000);
		queue_req(bls_pkg::REQ_SEARCH, -32'sd1);

		// Random: phases that lean toward filling, draining or a mix, so the list
		// reaches full and empty repeatedly. Removes and searches mostly name a
		// stored value; the rest are misses and the spare code.
		made = 0;
		while (made < RANDOM_REQS) begin
			mode = $urandom_range(2);
			span = $urandom_range(140, 60);
			for (int n = 0; n < span && made < RANDOM_REQS; n++) begin
				roll = $urandom_range(99);
				case (mode)
				0: kind = (roll < 75) ? bls_pkg::REQ_ADD : (roll < 85) ? bls_pkg::REQ_REMOVE :
					(roll < 97) ? bls_pkg::REQ_SEARCH : bls_pkg::REQ_NOP;
				1: kind = (roll < 20) ? bls_pkg::REQ_ADD : (roll < 75) ? bls_pkg::REQ_REMOVE :
					(roll < 97) ? bls_pkg::REQ_SEARCH : bls_pkg::REQ_NOP;
				default: kind = (roll < 40) ? bls_pkg::REQ_ADD :
					(roll < 70) ? bls_pkg::REQ_REMOVE :
					(roll < 97) ? bls_pkg::REQ_SEARCH : bls_pkg::REQ_NOP;
				endcase
				case (kind)
				bls_pkg::REQ_ADD: begin
					v = pick_add_value();
					if (held_values.size() < LIST_DEPTH)
						held_values.push_back(v);
				end
				bls_pkg::REQ_REMOVE: begin
					if (held_values.size() != 0 && $urandom_range(99) < 85) begin
						idx = $urandom_range(held_values.size() - 1);
						v = held_values[idx];
						held_values.delete(idx);
					end else begin
						v = $signed($urandom);
					end
				end
				bls_pkg::REQ_SEARCH: begin
					if (held_values.size() != 0 && $urandom_range(99) < 80)
						v = held_values[$urandom_range(held_values.size() - 1)];
					else
						v = $signed($urandom);
				end
				default: v = $signed($urandom);
				endcase
				queue_req(kind, v);
				made++;
			end
		end

		// Release reset on a rising edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every response to come back.
		while (pending_reqs.size() != 0)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses to %0d requests: %0d adds rejected on a full list,",
			rcv_cnt, sent_cnt, n_rejected);
		$display("  %0d misses, %0d results at full, %0d at empty, %0d field mismatches.",
			n_missed, n_full_seen, n_empty_seen, fail_cnt);
		if (fail_cnt == 0)
			$display("PASS bounded_list_search_minmax");
		else
			$display("FAIL bounded_list_search_minmax");
		$finish;
	end

endmodule
